/* design/chte_pkg.sv */
`default_nettype none
package chte_pkg;

    localparam int ENTRIES    = 64;
    localparam int ENT_AW     = 6;
    localparam int PTR_W      = 7;
    localparam int BUCKETS    = 16;
    localparam int BKT_W      = 4;
    localparam int KEY_BYTES  = 8;
    localparam int MAX_SELECT = 16;
    localparam int GROUP_W    = 3;
    localparam int GROUP_SIZE = 8;
    localparam int SUM_W      = 32;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SELECT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_LEN    = 3'd1,
        STAT_ZERO_PAY   = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_BAD_HANDLE = 3'd4,
        STAT_NONE       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_BUCKET_COUNT = 2'd0,
        CFG_KEY_LIMIT    = 2'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HASH,
        ST_DIV,
        ST_INS_WR,
        ST_INS_LINK,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_SEL_HEAD,
        ST_SEL_RD,
        ST_SEL_CHK,
        ST_SEL_END,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  handle;
        logic [31:0] payload;
        logic [4:0]  given;
    } res_t;

    // Keeps the low len bytes of a key; a length of 8 or more keeps all.
    function automatic logic [63:0] key_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '1;
        if (len == 4'd0)
        begin
            m = '0;
        end
        else if (len < 4'd8)
        begin
            m = ~(64'hFFFF_FFFF_FFFF_FFFF << {len[2:0], 3'b000});
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* design/chte_req_if.sv */
`default_nettype none
interface chte_req_if
    import chte_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] key;
    logic [3:0]  key_bytes;
    logic [31:0] payload;
    logic [5:0]  handle;
    logic [5:0]  skip_count;
    logic [4:0]  max_count;

    modport source (output valid, kind, key, key_bytes, payload, handle, skip_count,
                    max_count, input ready);
    modport sink (input valid, kind, key, key_bytes, payload, handle, skip_count,
                  max_count, output ready);
endinterface
`default_nettype wire

/* design/chte_rsp_if.sv */
`default_nettype none
interface chte_rsp_if
    import chte_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  handle_out;
    logic [31:0] found_payload;
    logic [4:0]  given_count;
    logic        last;

    modport source (output valid, status, handle_out, found_payload, given_count, last,
                    input ready);
    modport sink (input valid, status, handle_out, found_payload, given_count, last,
                  output ready);
endinterface
`default_nettype wire

/* design/chte_ram.sv */
`default_nettype none
module chte_ram
    import chte_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* design/chte_hash.sv */
`default_nettype none
module chte_hash
    import chte_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [63:0]      key,
    input  wire logic [3:0]       len,
    input  wire logic [4:0]       modulus,
    output logic                  done,
    output logic [BKT_W-1:0]      bucket
);
    // Byte sum of the masked key, then a restoring remainder one bit a cycle.
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] term_byte;
    logic [SUM_W-1:0] term_half;
    logic [SUM_W-1:0] term_word;
    logic [SUM_W-1:0] term_high;
    logic [1:0]       pos;
    logic [63:0]      shifted;

    logic [SUM_W-1:0] sum_reg;
    logic [BKT_W-1:0] rem_reg;
    logic [4:0]       mod_reg;
    logic [4:0]       bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [BKT_W:0]   rem_wide;
    logic [BKT_W:0]   rem_sub;

    always_comb
    begin
        term_byte = len[0] ? {24'd0, key[7:0]} : '0;
        term_half = '0;
        if (len[1])
        begin
            term_half = len[0] ? {16'd0, key[23:8]} : {16'd0, key[15:0]};
        end
        pos       = {1'b0, len[0]} + {len[1], 1'b0};
        shifted   = key >> {pos, 3'b000};
        term_word = (len[3:2] != 2'b00) ? shifted[31:0] : '0;
        term_high = len[3] ? key[63:32] : '0;
        sum       = term_byte + term_half + term_word + term_high;
        rem_wide  = {rem_reg, sum_reg[SUM_W-1]};
        rem_sub   = rem_wide - mod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= sum;
            rem_reg <= '0;
            mod_reg <= modulus;
            bit_reg <= '0;
        end
        else if (busy_reg)
        begin
            sum_reg <= {sum_reg[SUM_W-2:0], 1'b0};
            rem_reg <= (rem_wide >= mod_reg) ? rem_sub[BKT_W-1:0] : rem_wide[BKT_W-1:0];
            bit_reg <= bit_reg + 5'd1;
        end
    end

    assign done   = done_reg;
    assign bucket = rem_reg;
endmodule
`default_nettype wire

/* design/chained_hash_table_engine.sv */
`default_nettype none
// Chained hash table engine: a 64-entry store spread over up to 16 bucket chains.
// Items arrive on req (kind 0 insert, 1 delete by handle, 2 select by key) and
// results leave on rsp; both use valid/ready and move an item when both are high.
// Two registers, bucket count and key limit, are set through cfg_we, cfg_index and
// cfg_data; the user sets them while the block is idle; the block does not enforce it.
// The block works on one item at a time and drops req.ready until its last result
// is in the output register. An insert scans for a free slot, eight valid bits
// a cycle, then hashes the key and links the entry at the tail of its chain; a
// full store answers once the scan ends. A delete reads the entry and unlinks it.
// A select hashes the key and walks the chain one entry at a time. Rejected
// items answer without further work; an unused kind gives no result.
// The hash is a 32-bit byte sum reduced modulo the bucket count by a shared
// restoring remainder unit, one bit per cycle, which dominates the latency.
// Reset clears all valid marks and empties every chain at once; no clearing pass.
// A stalled receiver holds the output register; the walk waits when another result must go out.
module chained_hash_table_engine
    import chte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_data,
    chte_req_if.sink        req,
    chte_rsp_if.source      rsp
);
    state_t state_reg, state_next;

    logic [4:0]       bcount_reg;
    logic [3:0]       klimit_reg;
    logic [4:0]       modulus;
    logic [3:0]       limit;

    logic [1:0]       kind_reg;
    logic [63:0]      key_reg;
    logic [3:0]       len_reg;
    logic [31:0]      pay_reg;
    logic [5:0]       hnd_reg;
    logic [5:0]       skip_reg;
    logic [4:0]       maxc_reg;
    logic [4:0]       maxc_in;

    logic [GROUP_W-1:0] grp_reg, grp_next;
    logic [ENT_AW-1:0]  slot_reg, slot_next;
    logic [BKT_W-1:0]   bkt_reg, bkt_next;
    logic [PTR_W-1:0]   cur_reg, cur_next;
    logic [PTR_W-1:0]   steps_reg, steps_next;
    logic [PTR_W-1:0]   match_reg, match_next;
    logic [4:0]         given_reg, given_next;
    logic               pend_reg, pend_next;
    res_t               res_reg, res_next;
    res_t               out_reg, out_next;
    logic               out_last_reg, out_last_next;
    logic               out_v_reg, out_v_next;

    logic [ENTRIES-1:0] valid_reg;
    logic [PTR_W-1:0]   head_reg [BUCKETS];
    logic [PTR_W-1:0]   tail_reg [BUCKETS];

    logic               accept;
    logic               can_push;
    logic               hash_start;
    logic               hash_done;
    logic [BKT_W-1:0]   hash_bucket;

    logic               vset, vclr;
    logic               head_we, tail_we;
    logic [BKT_W-1:0]   head_idx, tail_idx;
    logic [PTR_W-1:0]   head_val, tail_val;

    logic               ent_we;
    logic               next_we, prev_we;
    logic [ENT_AW-1:0]  next_waddr, prev_waddr;
    logic [PTR_W-1:0]   next_wdata, prev_wdata;
    logic [ENT_AW-1:0]  raddr;
    logic [67:0]        key_rd;
    logic [31:0]        val_rd;
    logic [BKT_W-1:0]   bkt_rd;
    logic [PTR_W-1:0]   next_rd, prev_rd;

    logic [GROUP_SIZE-1:0] free_bits;
    logic [GROUP_W-1:0]    free_pos;
    logic                  hit;
    logic                  take;

    function automatic logic [GROUP_W-1:0] lowest_one(input logic [GROUP_SIZE-1:0] v);
        logic [GROUP_W-1:0] p;
        p = '0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                p = GROUP_W'(i);
            end
        end
        return p;
    endfunction

    // Out-of-range register values fold to the nearest legal value.
    always_comb
    begin
        modulus = bcount_reg;
        if (bcount_reg == 5'd0)
        begin
            modulus = 5'd1;
        end
        else if (bcount_reg > 5'(BUCKETS))
        begin
            modulus = 5'(BUCKETS);
        end
        limit   = (klimit_reg > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : klimit_reg;
        maxc_in = (req.max_count > 5'(MAX_SELECT)) ? 5'(MAX_SELECT) : req.max_count;
    end

    chte_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hash_start),
        .key     (key_reg),
        .len     (len_reg),
        .modulus (modulus),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    // Entry store: key with length, payload, owning bucket and the two chain links.
    chte_ram #(.WIDTH(68), .DEPTH(ENTRIES)) u_key_ram (
        .clk(clk), .we(ent_we), .waddr(slot_reg), .wdata({len_reg, key_reg}),
        .raddr(raddr), .rdata(key_rd)
    );
    chte_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_val_ram (
        .clk(clk), .we(ent_we), .waddr(slot_reg), .wdata(pay_reg),
        .raddr(raddr), .rdata(val_rd)
    );
    chte_ram #(.WIDTH(BKT_W), .DEPTH(ENTRIES)) u_bkt_ram (
        .clk(clk), .we(ent_we), .waddr(slot_reg), .wdata(bkt_reg),
        .raddr(raddr), .rdata(bkt_rd)
    );
    chte_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(raddr), .rdata(next_rd)
    );
    chte_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(raddr), .rdata(prev_rd)
    );

    assign accept    = req.valid && req.ready;
    assign can_push  = !out_v_reg || rsp.ready;
    assign free_bits = ~valid_reg[{grp_reg, 3'b000} +: GROUP_SIZE];
    assign free_pos  = lowest_one(free_bits);
    assign hit       = valid_reg[cur_reg[ENT_AW-1:0]] && key_rd[67:64] == len_reg
                       && key_rd[63:0] == key_reg;
    assign take      = hit && (match_reg >= {1'b0, skip_reg});

    always_comb
    begin
        state_next    = state_reg;
        grp_next      = grp_reg;
        slot_next     = slot_reg;
        bkt_next      = bkt_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        match_next    = match_reg;
        given_next    = given_reg;
        pend_next     = pend_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_v_next    = out_v_reg && !rsp.ready;
        req.ready     = 1'b0;
        hash_start    = 1'b0;
        vset          = 1'b0;
        vclr          = 1'b0;
        head_we       = 1'b0;
        tail_we       = 1'b0;
        head_idx      = bkt_reg;
        tail_idx      = bkt_reg;
        head_val      = NIL;
        tail_val      = NIL;
        ent_we        = 1'b0;
        next_we       = 1'b0;
        prev_we       = 1'b0;
        next_waddr    = slot_reg;
        prev_waddr    = slot_reg;
        next_wdata    = NIL;
        prev_wdata    = NIL;
        raddr         = cur_reg[ENT_AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                grp_next  = '0;
                res_next  = '0;
                if (req.valid)
                begin
                    priority case (req.kind)
                        KIND_INSERT:
                        begin
                            if (req.key_bytes == 4'd0 || req.key_bytes > limit)
                            begin
                                res_next.status = STAT_BAD_LEN;
                                state_next      = ST_RESP;
                            end
                            else if (req.payload == 32'd0)
                            begin
                                res_next.status = STAT_ZERO_PAY;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_DELETE:
                        begin
                            res_next.handle = req.handle;
                            if (!valid_reg[req.handle])
                            begin
                                res_next.status = STAT_BAD_HANDLE;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_DEL_RD;
                            end
                        end
                        KIND_SELECT:
                        begin
                            if (maxc_in == 5'd0 || req.key_bytes == 4'd0
                                || req.key_bytes > 4'(KEY_BYTES))
                            begin
                                res_next.status = STAT_NONE;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_HASH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (free_bits != '0)
                begin
                    slot_next  = {grp_reg, free_pos};
                    state_next = ST_HASH;
                end
                else if (grp_reg == '1)
                begin
                    res_next.status = STAT_FULL;
                    state_next      = ST_RESP;
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end

            ST_HASH:
            begin
                hash_start = 1'b1;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (hash_done)
                begin
                    bkt_next   = hash_bucket;
                    state_next = (kind_reg == KIND_INSERT) ? ST_INS_WR : ST_SEL_HEAD;
                end
            end

            // New entry goes to the tail of its chain.
            ST_INS_WR:
            begin
                ent_we     = 1'b1;
                vset       = 1'b1;
                next_we    = 1'b1;
                prev_we    = 1'b1;
                prev_wdata = tail_reg[bkt_reg];
                tail_we    = 1'b1;
                tail_val   = {1'b0, slot_reg};
                cur_next   = tail_reg[bkt_reg];
                res_next.status = STAT_OK;
                res_next.handle = slot_reg;
                if (tail_reg[bkt_reg] == NIL)
                begin
                    head_we    = 1'b1;
                    head_val   = {1'b0, slot_reg};
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_INS_LINK;
                end
            end

            ST_INS_LINK:
            begin
                next_we    = 1'b1;
                next_waddr = cur_reg[ENT_AW-1:0];
                next_wdata = {1'b0, slot_reg};
                state_next = ST_RESP;
            end

            ST_DEL_RD:
            begin
                raddr      = hnd_reg;
                state_next = ST_DEL_WR;
            end

            ST_DEL_WR:
            begin
                raddr    = hnd_reg;
                vclr     = 1'b1;
                head_idx = bkt_rd;
                tail_idx = bkt_rd;
                if (prev_rd != NIL)
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd[ENT_AW-1:0];
                    next_wdata = next_rd;
                end
                else
                begin
                    head_we  = 1'b1;
                    head_val = next_rd;
                end
                if (next_rd != NIL)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd[ENT_AW-1:0];
                    prev_wdata = prev_rd;
                end
                else
                begin
                    tail_we  = 1'b1;
                    tail_val = prev_rd;
                end
                res_next.status = STAT_OK;
                state_next      = ST_RESP;
            end

            ST_SEL_HEAD:
            begin
                cur_next   = head_reg[bkt_reg];
                steps_next = '0;
                match_next = '0;
                given_next = '0;
                pend_next  = 1'b0;
                state_next = (head_reg[bkt_reg] == NIL) ? ST_SEL_END : ST_SEL_RD;
            end

            ST_SEL_RD:
            begin
                state_next = ST_SEL_CHK;
            end

            // One chain entry per visit; an earlier match is held back until the
            // next one is found, so that the final result can carry last.
            ST_SEL_CHK:
            begin
                if (!(take && pend_reg && !can_push))
                begin
                    if (take)
                    begin
                        if (pend_reg)
                        begin
                            out_v_next    = 1'b1;
                            out_next      = res_reg;
                            out_last_next = 1'b0;
                        end
                        res_next.status  = STAT_OK;
                        res_next.handle  = cur_reg[ENT_AW-1:0];
                        res_next.payload = val_rd;
                        res_next.given   = given_reg + 5'd1;
                        pend_next        = 1'b1;
                        given_next       = given_reg + 5'd1;
                    end
                    if (hit)
                    begin
                        match_next = match_reg + 1'b1;
                    end
                    cur_next   = next_rd;
                    steps_next = steps_reg + 1'b1;
                    if (next_rd != NIL && steps_next != PTR_W'(ENTRIES)
                        && given_next < maxc_reg)
                    begin
                        state_next = ST_SEL_RD;
                    end
                    else
                    begin
                        state_next = ST_SEL_END;
                    end
                end
            end

            ST_SEL_END:
            begin
                if (!pend_reg)
                begin
                    res_next        = '0;
                    res_next.status = STAT_NONE;
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (can_push)
                begin
                    out_v_next    = 1'b1;
                    out_next      = res_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            out_v_reg  <= 1'b0;
            pend_reg   <= 1'b0;
            bcount_reg <= 5'd16;
            klimit_reg <= 4'd8;
            valid_reg  <= '0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
            pend_reg  <= pend_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_BUCKET_COUNT)
                begin
                    bcount_reg <= cfg_data;
                end
                else if (cfg_index == CFG_KEY_LIMIT)
                begin
                    klimit_reg <= cfg_data[3:0];
                end
            end
            if (vset)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (vclr)
            begin
                valid_reg[hnd_reg] <= 1'b0;
            end
            if (head_we)
            begin
                head_reg[head_idx] <= head_val;
            end
            if (tail_we)
            begin
                tail_reg[tail_idx] <= tail_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req.kind;
            key_reg  <= req.key & key_mask(req.key_bytes);
            len_reg  <= req.key_bytes;
            pay_reg  <= req.payload;
            hnd_reg  <= req.handle;
            skip_reg <= req.skip_count;
            maxc_reg <= maxc_in;
        end
        grp_reg      <= grp_next;
        slot_reg     <= slot_next;
        bkt_reg      <= bkt_next;
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
        match_reg    <= match_next;
        given_reg    <= given_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid         = out_v_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.handle_out    = out_reg.handle;
    assign rsp.found_payload = out_reg.payload;
    assign rsp.given_count   = out_reg.given;
    assign rsp.last          = out_last_reg;
endmodule
`default_nettype wire

/* tb/chained_hash_table_engine_test.sv */
`default_nettype none
module chained_hash_table_engine_test;
    import chte_pkg::*;

    // One request as the driver presents it on the req channel.
    typedef struct {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [3:0]  key_bytes;
        logic [31:0] payload;
        logic [5:0]  handle;
        logic [5:0]  skip_count;
        logic [4:0]  max_count;
    } request_t;

    // One response as the monitor expects it on the rsp channel.
    typedef struct {
        logic [2:0]  status;
        logic [5:0]  handle_out;
        logic [31:0] found_payload;
        logic [4:0]  given_count;
        logic        last;
    } response_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;

    chte_req_if req_ch ();
    chte_rsp_if rsp_ch ();

    chained_hash_table_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Requests waiting to be driven and responses still owed by the block.
    request_t  pending_reqs[$];
    response_t owed_rsps[$];

    // The testbench's own copy of the table.
    logic [63:0] tbl_key[ENTRIES];
    logic [3:0]  tbl_len[ENTRIES];
    logic [31:0] tbl_value[ENTRIES];
    bit          tbl_live[ENTRIES];
    int          tbl_bucket[ENTRIES];
    int          tbl_next[ENTRIES];
    int          tbl_prev[ENTRIES];
    int          chain_head[BUCKETS];
    int          chain_tail[BUCKETS];
    int          live_count;
    logic [4:0]  cur_buckets;
    logic [3:0]  cur_key_limit;

    // Key pool used to build inserts and selects that hit the same chains.
    logic [63:0] pool_key[6];
    logic [3:0]  pool_len[6];

    int  error_count;
    int  idle_cycles;
    bit  no_idling;

    localparam int HOLD_OFF  = 80;
    localparam int WDOG_LIMIT = 4000;

    // The clock runs from time zero; reset is held low at the start of the run.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        if (len == 4'd0)
        begin
            return 64'd0;
        end
        if (len >= 4'd8)
        begin
            return '1;
        end
        return ~(64'hFFFF_FFFF_FFFF_FFFF << (8 * len));
    endfunction

    function automatic logic [31:0] key_byte_at(input logic [63:0] k, input int pos);
        return 32'((k >> (8 * (pos & 7))) & 64'hFF);
    endfunction

    // Little-endian byte sum: odd leading byte, then a half word, then words,
    // reduced by the bucket count in use (0 counts as 1, above 16 as 16).
    function automatic int bucket_for(input logic [63:0] k, input logic [3:0] len);
        logic [31:0] sum;
        int          pos;
        int          modulus;
        sum = 32'd0;
        pos = 0;
        modulus = cur_buckets;
        if (modulus == 0)
        begin
            modulus = 1;
        end
        if (modulus > BUCKETS)
        begin
            modulus = BUCKETS;
        end
        if (len[0])
        begin
            sum += key_byte_at(k, 0);
            pos = 1;
        end
        if (len[1])
        begin
            sum += key_byte_at(k, pos) | (key_byte_at(k, pos + 1) << 8);
            pos += 2;
        end
        for (int n = 0; n < int'(len >> 2) && pos + 3 < 8; n++)
        begin
            sum += key_byte_at(k, pos) | (key_byte_at(k, pos + 1) << 8)
                 | (key_byte_at(k, pos + 2) << 16) | (key_byte_at(k, pos + 3) << 24);
            pos += 4;
        end
        return int'(sum % modulus);
    endfunction

    function automatic void owe(input logic [2:0] st, input int h, input logic [31:0] pay,
                                input int given, input logic last);
        response_t r;
        r.status = st;
        r.handle_out = 6'(h);
        r.found_payload = pay;
        r.given_count = 5'(given);
        r.last = last;
        owed_rsps.push_back(r);
    endfunction

    // Applies one accepted request to the table copy and queues its responses.
    function automatic void apply_request(input request_t q);
        int          lim;
        int          h;
        int          b;
        int          p;
        int          n;
        int          cur;
        int          steps;
        int          match_total;
        int          given;
        int          maxc;
        logic [63:0] k;
        lim = (cur_key_limit > KEY_BYTES) ? KEY_BYTES : cur_key_limit;
        case (q.kind)
            KIND_INSERT:
            begin
                if (q.key_bytes == 0 || q.key_bytes > lim)
                begin
                    owe(STAT_BAD_LEN, 0, 0, 0, 1'b1);
                end
                else if (q.payload == 0)
                begin
                    owe(STAT_ZERO_PAY, 0, 0, 0, 1'b1);
                end
                else
                begin
                    h = 0;
                    while (h < ENTRIES && tbl_live[h])
                    begin
                        h++;
                    end
                    if (h >= ENTRIES)
                    begin
                        owe(STAT_FULL, 0, 0, 0, 1'b1);
                    end
                    else
                    begin
                        k = q.key & byte_mask(q.key_bytes);
                        b = bucket_for(k, q.key_bytes);
                        tbl_key[h] = k;
                        tbl_len[h] = q.key_bytes;
                        tbl_value[h] = q.payload;
                        tbl_live[h] = 1'b1;
                        tbl_bucket[h] = b;
                        tbl_next[h] = ENTRIES;
                        tbl_prev[h] = chain_tail[b];
                        if (chain_tail[b] < ENTRIES)
                        begin
                            tbl_next[chain_tail[b]] = h;
                        end
                        else
                        begin
                            chain_head[b] = h;
                        end
                        chain_tail[b] = h;
                        live_count++;
                        owe(STAT_OK, h, 0, 0, 1'b1);
                    end
                end
            end
            KIND_DELETE:
            begin
                h = q.handle;
                if (!tbl_live[h])
                begin
                    owe(STAT_BAD_HANDLE, h, 0, 0, 1'b1);
                end
                else
                begin
                    b = tbl_bucket[h];
                    p = tbl_prev[h];
                    n = tbl_next[h];
                    if (p < ENTRIES)
                    begin
                        tbl_next[p] = n;
                    end
                    else
                    begin
                        chain_head[b] = n;
                    end
                    if (n < ENTRIES)
                    begin
                        tbl_prev[n] = p;
                    end
                    else
                    begin
                        chain_tail[b] = p;
                    end
                    tbl_live[h] = 1'b0;
                    live_count--;
                    owe(STAT_OK, h, 0, 0, 1'b1);
                end
            end
            KIND_SELECT:
            begin
                maxc = (q.max_count > MAX_SELECT) ? MAX_SELECT : q.max_count;
                given = 0;
                if (maxc != 0 && q.key_bytes != 0 && q.key_bytes <= KEY_BYTES)
                begin
                    k = q.key & byte_mask(q.key_bytes);
                    cur = chain_head[bucket_for(k, q.key_bytes)];
                    steps = 0;
                    match_total = 0;
                    while (cur < ENTRIES && steps < ENTRIES && given < maxc)
                    begin
                        if (tbl_live[cur] && tbl_len[cur] == q.key_bytes && tbl_key[cur] == k)
                        begin
                            if (match_total >= q.skip_count)
                            begin
                                owe(STAT_OK, cur, tbl_value[cur], given + 1, 1'b0);
                                given++;
                            end
                            match_total++;
                        end
                        cur = tbl_next[cur];
                        steps++;
                    end
                end
                if (given == 0)
                begin
                    owe(STAT_NONE, 0, 0, 0, 1'b1);
                end
                else
                begin
                    owed_rsps[owed_rsps.size() - 1].last = 1'b1;
                end
            end
            default:
            begin
                // The unused kind is swallowed without a response.
            end
        endcase
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idling)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Driver: presents queued requests and records each accepted one.
    request_t drv_item;
    int       drv_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.kind <= '0;
            req_ch.key <= '0;
            req_ch.key_bytes <= '0;
            req_ch.payload <= '0;
            req_ch.handle <= '0;
            req_ch.skip_count <= '0;
            req_ch.max_count <= '0;
            drv_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_request(drv_item);
            end
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    drv_item = pending_reqs.pop_front();
                    req_ch.kind <= drv_item.kind;
                    req_ch.key <= drv_item.key;
                    req_ch.key_bytes <= drv_item.key_bytes;
                    req_ch.payload <= drv_item.payload;
                    req_ch.handle <= drv_item.handle;
                    req_ch.skip_count <= drv_item.skip_count;
                    req_ch.max_count <= drv_item.max_count;
                    req_ch.valid <= 1'b1;
                    drv_gap = pick_gap();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every accepted response with the oldest owed one,
    // and stalls the response channel at random.
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (owed_rsps.size() == 0)
                begin
                    $error("response with none owed: status %0d handle %0d",
                           rsp_ch.status, rsp_ch.handle_out);
                    error_count++;
                end
                else
                begin
                    want = owed_rsps.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.handle_out !== want.handle_out)
                    begin
                        $error("handle_out: expected %0d, got %0d",
                               want.handle_out, rsp_ch.handle_out);
                        error_count++;
                    end
                    if (rsp_ch.found_payload !== want.found_payload)
                    begin
                        $error("found_payload: expected %h, got %h",
                               want.found_payload, rsp_ch.found_payload);
                        error_count++;
                    end
                    if (rsp_ch.given_count !== want.given_count)
                    begin
                        $error("given_count: expected %0d, got %0d",
                               want.given_count, rsp_ch.given_count);
                        error_count++;
                    end
                    if (rsp_ch.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                rsp_ch.ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic void add_request(input logic [1:0] kind, input logic [63:0] key,
                                        input logic [3:0] len, input logic [31:0] pay,
                                        input logic [5:0] h, input logic [5:0] skip,
                                        input logic [4:0] maxc);
        request_t q;
        q.kind = kind;
        q.key = key;
        q.key_bytes = len;
        q.payload = pay;
        q.handle = h;
        q.skip_count = skip;
        q.max_count = maxc;
        pending_reqs.push_back(q);
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // New pool of keys; lengths are kept within the given limit.
    function automatic void fresh_pool(input int max_len);
        for (int i = 0; i < 6; i++)
        begin
            pool_key[i] = rand_key();
            pool_len[i] = 4'($urandom_range(1, max_len));
        end
    endfunction

    // A pool key with fresh junk in the bytes past its length.
    function automatic logic [63:0] pool_pick(input int i);
        logic [63:0] m;
        m = byte_mask(pool_len[i]);
        return (pool_key[i] & m) | (rand_key() & ~m);
    endfunction

    // One random request: mostly inserts and selects over the pool, some
    // deletes of likely live handles, and a little noise.
    function automatic void add_random_request();
        int          r;
        int          i;
        logic [3:0]  len;
        logic [31:0] pay;
        r = $urandom_range(0, 99);
        i = $urandom_range(0, 5);
        len = pool_len[i];
        if ($urandom_range(0, 9) == 0)
        begin
            len = 4'($urandom_range(0, 8));
        end
        if (r < 40)
        begin
            pay = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom();
            add_request(KIND_INSERT, pool_pick(i), len, pay, 6'($urandom()),
                        6'($urandom()), 5'($urandom()));
        end
        else if (r < 62)
        begin
            add_request(KIND_DELETE, rand_key(), 4'($urandom_range(0, 8)), $urandom(),
                        ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 15)),
                        6'($urandom()), 5'($urandom()));
        end
        else if (r < 97)
        begin
            add_request(KIND_SELECT, pool_pick(i), len, $urandom(), 6'($urandom()),
                        ($urandom_range(0, 4) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 3)),
                        5'($urandom_range(0, 16)));
        end
        else
        begin
            add_request(2'd3, rand_key(), 4'($urandom_range(0, 8)), $urandom(),
                        6'($urandom()), 6'($urandom()), 5'($urandom()));
        end
    endfunction

    // Waits until every request is taken and answered, then lets the block
    // finish any request that produced no response. The check runs on the
    // falling edge so that the driver's updates of the rising edge are seen.
    task automatic drain();
        while (pending_reqs.size() != 0 || req_ch.valid || owed_rsps.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [4:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_BUCKET_COUNT)
        begin
            cur_buckets = val;
        end
        else
        begin
            cur_key_limit = val[3:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        idle_cycles = 0;
        no_idling = 1'b0;
        live_count = 0;
        cur_buckets = 5'd16;
        cur_key_limit = 4'd8;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_live[i] = 1'b0;
            tbl_next[i] = ENTRIES;
            tbl_prev[i] = ENTRIES;
        end
        for (int b = 0; b < BUCKETS; b++)
        begin
            chain_head[b] = ENTRIES;
            chain_tail[b] = ENTRIES;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: every operation, the field
        // extremes, each reject path but a full store, and the empty selects.
        add_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 32'd1, 6'd0, 6'd0, 5'd0);
        add_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF, 6'd63,
                    6'd63, 5'd31);
        add_request(KIND_INSERT, 64'h0123_4567_89AB_CDEF, 4'd0, 32'd5, 6'd0, 6'd0, 5'd0);
        add_request(KIND_INSERT, 64'h0123_4567_89AB_CDEF, 4'd3, 32'd0, 6'd0, 6'd0, 5'd0);
        for (int n = 2; n <= 7; n++)
        begin
            add_request(KIND_INSERT, 64'hA5A5_5A5A_F00F_0FF0, 4'(n), 32'(n * 3), 6'd0, 6'd0, 5'd0);
        end
        // Same key twice, so a select can skip and count.
        add_request(KIND_INSERT, 64'hDEAD_0000_0000_0EEF, 4'd3, 32'h1111, 6'd0, 6'd0, 5'd0);
        add_request(KIND_INSERT, 64'h1234_0000_0000_0EEF, 4'd3, 32'h2222, 6'd0, 6'd0, 5'd0);
        add_request(KIND_SELECT, 64'h0000_0000_0000_0EEF, 4'd3, 32'd0, 6'd0, 6'd0, 5'd16);
        add_request(KIND_SELECT, 64'h0000_0000_0000_0EEF, 4'd3, 32'd0, 6'd0, 6'd1, 5'd16);
        add_request(KIND_SELECT, 64'h0000_0000_0000_0EEF, 4'd3, 32'd0, 6'd0, 6'd63, 5'd16);
        add_request(KIND_SELECT, 64'h0000_0000_0000_0EEF, 4'd3, 32'd0, 6'd0, 6'd0, 5'd0);
        add_request(KIND_SELECT, 64'h0000_0000_0000_0EEF, 4'd0, 32'd0, 6'd0, 6'd0, 5'd1);
        add_request(KIND_SELECT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0, 6'd0, 6'd0, 5'd31);
        add_request(KIND_DELETE, 64'd0, 4'd0, 32'd0, 6'd63, 6'd0, 5'd0);
        add_request(KIND_DELETE, 64'd0, 4'd0, 32'd0, 6'd0, 6'd0, 5'd0);
        add_request(KIND_DELETE, 64'd0, 4'd0, 32'd0, 6'd0, 6'd0, 5'd0);
        add_request(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF, 6'd63, 6'd63, 5'd31);
        add_request(KIND_SELECT, 64'h0000_0000_0000_0EEF, 4'd3, 32'd0, 6'd0, 6'd0, 5'd1);
        drain();

        // One bucket: fill the store past its capacity, then select and
        // delete over the long chain. This phase runs without idling.
        no_idling = 1'b1;
        write_reg(CFG_BUCKET_COUNT, 5'd1);
        fresh_pool(8);
        for (int n = 0; n < 66; n++)
        begin
            add_request(KIND_INSERT, pool_pick(n % 3), pool_len[n % 3], $urandom() | 32'd1,
                        6'($urandom()), 6'($urandom()), 5'($urandom()));
        end
        for (int n = 0; n < 14; n++)
        begin
            add_random_request();
        end
        drain();
        no_idling = 1'b0;

        // Bucket count zero (acts as one) and a key limit of zero: every insert is
        // turned away while entries placed in the one-bucket phase stay reachable.
        write_reg(CFG_BUCKET_COUNT, 5'd0);
        write_reg(CFG_KEY_LIMIT, 5'd0);
        for (int n = 0; n < 30; n++)
        begin
            add_random_request();
        end
        for (int n = 0; n < 40; n++)
        begin
            add_request(KIND_DELETE, 64'd0, 4'd0, 32'd0, 6'(n), 6'd0, 5'd0);
        end
        drain();

        // Oversized settings clamp to sixteen buckets and eight bytes.
        write_reg(CFG_BUCKET_COUNT, 5'd31);
        write_reg(CFG_KEY_LIMIT, 5'd15);
        fresh_pool(8);
        for (int n = 0; n < 40; n++)
        begin
            add_random_request();
        end
        drain();

        // A middling bucket count and short keys.
        write_reg(CFG_BUCKET_COUNT, 5'd5);
        write_reg(CFG_KEY_LIMIT, 5'd3);
        fresh_pool(4);
        for (int n = 0; n < 40; n++)
        begin
            add_random_request();
        end
        drain();

        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
design/chte_pkg.sv
design/chte_req_if.sv
design/chte_rsp_if.sv
design/chte_ram.sv
design/chte_hash.sv
design/chained_hash_table_engine.sv
tb/chained_hash_table_engine_test.sv
